### rtl/nlq_pkg.sv
// Shared constants, types and register codes for the note lock qualifier.
package nlq_pkg;

    localparam int WINDOW  = 8;
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int OFF_W   = 16;
    localparam int SUM_W   = OFF_W + $clog2(WINDOW) + 1;
    localparam int HZ_W    = 16;
    localparam int NOTE_W  = 4;
    localparam int CNT_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int QDEPTH  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS    = 1'b1;

    localparam logic [CFG_W-1:0] CONFIRM_RESET = 8'd3;
    localparam logic [CFG_W-1:0] MISS_RESET    = 8'd3;
    localparam logic [CNT_W-1:0] CNT_MAX       = 8'hFF;

    typedef struct packed {
        logic [CFG_W-1:0] confirm_threshold;
        logic [CFG_W-1:0] miss_threshold;
    } cfg_t;

    // One classified frame on its way from the front to the back.
    typedef struct packed {
        logic                    pitch_seen;
        logic [NOTE_W-1:0]       note_out;
        logic [NOTE_W-1:0]       octave_out;
        logic                    confirmed;
        logic signed [SUM_W-1:0] sum;
        logic [FILL_W-1:0]       fill;
        logic [HZ_W-1:0]         freq_out;
        logic                    locked;
        logic                    changed;
    } job_t;

endpackage

### rtl/nlq_if.sv
// Channel interfaces for pitch frames in and qualified results out.
interface nlq_frame_if;
    import nlq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    pitch_present;
    logic [NOTE_W-1:0]       note_index;
    logic [NOTE_W-1:0]       octave_index;
    logic signed [OFF_W-1:0] semitone_offset;
    logic [HZ_W-1:0]         pitch_hz;

    modport source (output valid, pitch_present, note_index, octave_index,
                    semitone_offset, pitch_hz, input ready);
    modport sink (input valid, pitch_present, note_index, octave_index,
                  semitone_offset, pitch_hz, output ready);
endinterface

interface nlq_result_if;
    import nlq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    pitch_seen;
    logic [NOTE_W-1:0]       note_out;
    logic [NOTE_W-1:0]       octave_out;
    logic                    confirmed;
    logic signed [OFF_W-1:0] mean_offset;
    logic [HZ_W-1:0]         freq_out;
    logic                    locked;
    logic                    changed;

    modport source (output valid, pitch_seen, note_out, octave_out, confirmed,
                    mean_offset, freq_out, locked, changed, input ready);
    modport sink (input valid, pitch_seen, note_out, octave_out, confirmed,
                  mean_offset, freq_out, locked, changed, output ready);
endinterface

### rtl/nlq_front.sv
// Front end: accepts frames, updates hit, miss and lock state and the window.
module nlq_front
    import nlq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    frame_valid,
    output logic                    frame_ready,
    input  logic                    pitch_present,
    input  logic [NOTE_W-1:0]       note_index,
    input  logic [NOTE_W-1:0]       octave_index,
    input  logic signed [OFF_W-1:0] semitone_offset,
    input  logic [HZ_W-1:0]         pitch_hz,
    output logic                    job_valid,
    input  logic                    job_ready,
    output job_t                    job
);

    logic [NOTE_W-1:0]       last_note_reg,   last_note_next;
    logic [NOTE_W-1:0]       last_octave_reg, last_octave_next;
    logic                    last_valid_reg,  last_valid_next;
    logic [CNT_W-1:0]        hit_count_reg,   hit_count_next;
    logic [CNT_W-1:0]        miss_count_reg,  miss_count_next;
    logic                    lock_reg,        lock_next;
    logic [IDX_W-1:0]        head_reg,        head_next;
    logic [FILL_W-1:0]       fill_reg,        fill_next;
    logic signed [SUM_W-1:0] sum_reg,         sum_next;
    logic signed [OFF_W-1:0] window_reg [WINDOW];

    logic                    accept;
    logic                    note_change;
    logic                    win_we;
    logic [IDX_W-1:0]        win_addr;
    logic [FILL_W-1:0]       slot;
    logic signed [SUM_W-1:0] off_ext;
    logic                    confirmed;
    logic                    changed;

    assign frame_ready = job_ready;
    assign job_valid   = frame_valid;
    assign accept      = frame_valid && job_ready;
    assign off_ext     = SUM_W'(semitone_offset);
    assign note_change = !last_valid_reg || (note_index != last_note_reg)
                         || (octave_index != last_octave_reg);

    // Next free slot of the ring, used while the window is not yet full.
    always_comb
    begin
        slot = FILL_W'(head_reg) + fill_reg;
        if (slot >= FILL_W'(WINDOW))
        begin
            slot = slot - FILL_W'(WINDOW);
        end
    end

    always_comb
    begin
        last_note_next   = last_note_reg;
        last_octave_next = last_octave_reg;
        last_valid_next  = last_valid_reg;
        hit_count_next   = hit_count_reg;
        miss_count_next  = miss_count_reg;
        lock_next        = lock_reg;
        head_next        = head_reg;
        fill_next        = fill_reg;
        sum_next         = sum_reg;
        win_we           = 1'b0;
        win_addr         = '0;
        confirmed        = 1'b0;
        changed          = 1'b0;

        // A missed frame, or a pitched frame on a new note.
        if (!pitch_present || note_change)
        begin
            if (miss_count_reg != CNT_MAX)
            begin
                miss_count_next = miss_count_reg + CNT_W'(1);
            end
            if (miss_count_reg >= cfg.miss_threshold)
            begin
                hit_count_next = '0;
                if (lock_reg)
                begin
                    lock_next = 1'b0;
                    head_next = '0;
                    fill_next = '0;
                    sum_next  = '0;
                    changed   = 1'b1;
                end
            end
        end

        if (pitch_present && note_change)
        begin
            last_note_next   = note_index;
            last_octave_next = octave_index;
            last_valid_next  = 1'b1;
            // Clearing the hit count before or after the miss gives the same result.
            hit_count_next   = '0;
            head_next        = '0;
            fill_next        = FILL_W'(1);
            sum_next         = off_ext;
            win_we           = 1'b1;
            win_addr         = '0;
        end
        else if (pitch_present)
        begin
            if (hit_count_reg != CNT_MAX)
            begin
                hit_count_next = hit_count_reg + CNT_W'(1);
            end
            win_we = 1'b1;
            if (fill_reg >= FILL_W'(WINDOW))
            begin
                // Full ring: the oldest entry is overwritten by the new one.
                win_addr = head_reg;
                sum_next = sum_reg - SUM_W'(window_reg[head_reg]) + off_ext;
                if (head_reg == IDX_W'(WINDOW - 1))
                begin
                    head_next = '0;
                end
                else
                begin
                    head_next = head_reg + IDX_W'(1);
                end
            end
            else
            begin
                win_addr  = slot[IDX_W-1:0];
                fill_next = fill_reg + FILL_W'(1);
                sum_next  = sum_reg + off_ext;
            end
            if (hit_count_reg >= cfg.confirm_threshold)
            begin
                miss_count_next = '0;
                lock_next       = 1'b1;
                confirmed       = 1'b1;
                changed         = 1'b1;
            end
        end
    end

    always_comb
    begin
        job.pitch_seen = pitch_present;
        job.note_out   = pitch_present ? note_index   : '0;
        job.octave_out = pitch_present ? octave_index : '0;
        job.confirmed  = confirmed;
        job.sum        = sum_next;
        job.fill       = fill_next;
        job.freq_out   = confirmed ? pitch_hz : '0;
        job.locked     = lock_next;
        job.changed    = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_note_reg   <= '0;
            last_octave_reg <= '0;
            last_valid_reg  <= 1'b0;
            hit_count_reg   <= '0;
            miss_count_reg  <= '0;
            lock_reg        <= 1'b0;
            head_reg        <= '0;
            fill_reg        <= '0;
            sum_reg         <= '0;
        end
        else if (accept)
        begin
            last_note_reg   <= last_note_next;
            last_octave_reg <= last_octave_next;
            last_valid_reg  <= last_valid_next;
            hit_count_reg   <= hit_count_next;
            miss_count_reg  <= miss_count_next;
            lock_reg        <= lock_next;
            head_reg        <= head_next;
            fill_reg        <= fill_next;
            sum_reg         <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && win_we)
        begin
            window_reg[win_addr] <= semitone_offset;
        end
    end

endmodule

### rtl/nlq_queue.sv
// Short FIFO that decouples the front end from the back end.
module nlq_queue
    import nlq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_Q = $clog2(QDEPTH + 1);

    job_t             store_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_Q'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_Q'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_Q'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/nlq_back.sv
// Back end: serial signed division for the window mean and the result register.
module nlq_back
    import nlq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  job_t                    job,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic                    pitch_seen,
    output logic [NOTE_W-1:0]       note_out,
    output logic [NOTE_W-1:0]       octave_out,
    output logic                    confirmed,
    output logic signed [OFF_W-1:0] mean_offset,
    output logic [HZ_W-1:0]         freq_out,
    output logic                    locked,
    output logic                    changed
);

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [0:0] {ST_IDLE, ST_DIV} state_t;

    state_t              state_reg;
    job_t                job_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [FILL_W-1:0]   rem_reg;
    logic                neg_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                res_valid_reg;
    logic                pitch_seen_reg;
    logic [NOTE_W-1:0]   note_out_reg;
    logic [NOTE_W-1:0]   octave_out_reg;
    logic                confirmed_reg;
    logic [OFF_W-1:0]    mean_offset_reg;
    logic [HZ_W-1:0]     freq_out_reg;
    logic                locked_reg;
    logic                changed_reg;

    logic                take;
    logic                res_load;
    logic [SUM_W-1:0]    sum_mag;
    logic [FILL_W:0]     rem_shift;
    logic                fits;
    logic [FILL_W-1:0]   rem_next;
    logic [SUM_W-1:0]    quo_next;
    logic [SUM_W-1:0]    quo_signed;

    assign job_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign take      = job_valid && job_ready;
    assign sum_mag   = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);

    // A new result is loaded either straight from a job that does not confirm or at
    // the last step of the division.
    assign res_load  = (state_reg == ST_IDLE) ? (take && !job.confirmed)
                                              : (step_reg == STEP_W'(SUM_W - 1));

    // One restoring step: bring in the next dividend bit and try the divisor.
    always_comb
    begin
        rem_shift  = {rem_reg, quo_reg[SUM_W-1]};
        fits       = (rem_shift >= {1'b0, job_reg.fill});
        rem_next   = fits ? FILL_W'(rem_shift - {1'b0, job_reg.fill}) : rem_shift[FILL_W-1:0];
        quo_next   = {quo_reg[SUM_W-2:0], fits};
        quo_signed = neg_reg ? (-quo_next) : quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        job_reg <= job;
                        if (job.confirmed)
                        begin
                            quo_reg   <= sum_mag;
                            rem_reg   <= '0;
                            neg_reg   <= job.sum[SUM_W-1];
                            step_reg  <= '0;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            pitch_seen_reg  <= job.pitch_seen;
                            note_out_reg    <= job.note_out;
                            octave_out_reg  <= job.octave_out;
                            confirmed_reg   <= 1'b0;
                            mean_offset_reg <= '0;
                            freq_out_reg    <= job.freq_out;
                            locked_reg      <= job.locked;
                            changed_reg     <= job.changed;
                        end
                    end
                end
                ST_DIV:
                begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        pitch_seen_reg  <= job_reg.pitch_seen;
                        note_out_reg    <= job_reg.note_out;
                        octave_out_reg  <= job_reg.octave_out;
                        confirmed_reg   <= 1'b1;
                        mean_offset_reg <= quo_signed[OFF_W-1:0];
                        freq_out_reg    <= job_reg.freq_out;
                        locked_reg      <= job_reg.locked;
                        changed_reg     <= job_reg.changed;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid   = res_valid_reg;
    assign pitch_seen  = pitch_seen_reg;
    assign note_out    = note_out_reg;
    assign octave_out  = octave_out_reg;
    assign confirmed   = confirmed_reg;
    assign mean_offset = mean_offset_reg;
    assign freq_out    = freq_out_reg;
    assign locked      = locked_reg;
    assign changed     = changed_reg;

endmodule

### rtl/note_lock_qualifier.sv
// Top level of the note lock qualifier: configuration registers, front, queue and back.
//
// Each frame transfer carries one pitch estimate. The front end takes a frame in
// every cycle in which the two-entry queue has room, and in that same cycle decides
// whether the frame is a hit, a miss or a note change, updates the hit and miss
// counters, the lock flag and the eight-entry offset window with its running sum.
// The back end turns each classified frame into one result transfer held in an
// output register. A frame that does not confirm the note goes from the queue
// into the output register when the back end takes it, and such frames can follow
// one per cycle while the receiver takes each result. A confirming frame needs the
// window mean, which the back end works out with a restoring divider that produces
// one quotient bit per cycle; its result is loaded into the output register at the
// last division step, and the back end takes no new frame until then. The queue
// lets the front end keep taking frames during a division while it has room.
// Thresholds are written through the plain write port (index 0 confirm threshold,
// index 1 miss threshold, both reset to 3) and take effect for the next frame; they
// are to be written only while the block is idle.
module note_lock_qualifier
    import nlq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    nlq_frame_if.sink            frame,
    nlq_result_if.source         result
);

    cfg_t cfg_reg;
    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    // The threshold registers live here so that both can be read by the front end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_threshold <= CONFIRM_RESET;
            cfg_reg.miss_threshold    <= MISS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CONFIRM)
            begin
                cfg_reg.confirm_threshold <= cfg_data;
            end
            if (cfg_index == CFG_MISS)
            begin
                cfg_reg.miss_threshold <= cfg_data;
            end
        end
    end

    nlq_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .frame_valid     (frame.valid),
        .frame_ready     (frame.ready),
        .pitch_present   (frame.pitch_present),
        .note_index      (frame.note_index),
        .octave_index    (frame.octave_index),
        .semitone_offset (frame.semitone_offset),
        .pitch_hz        (frame.pitch_hz),
        .job_valid       (push_valid),
        .job_ready       (push_ready),
        .job             (push_data)
    );

    nlq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    nlq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (pop_valid),
        .job_ready   (pop_ready),
        .job         (pop_data),
        .res_valid   (result.valid),
        .res_ready   (result.ready),
        .pitch_seen  (result.pitch_seen),
        .note_out    (result.note_out),
        .octave_out  (result.octave_out),
        .confirmed   (result.confirmed),
        .mean_offset (result.mean_offset),
        .freq_out    (result.freq_out),
        .locked      (result.locked),
        .changed     (result.changed)
    );

    // A confirming result always reports the lock as held and as a change.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.confirmed |-> result.locked && result.changed)
    else $error("confirmed result without lock or change flag");

    // Mean and frequency are only non-zero on a confirming result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.confirmed |-> result.mean_offset == '0 && result.freq_out == '0)
    else $error("mean or frequency set on a result that did not confirm");

    // A frame without a pitch reports no note and cannot confirm.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.pitch_seen
        |-> result.note_out == '0 && result.octave_out == '0 && !result.confirmed)
    else $error("unpitched frame reported a note or a confirmation");

    // The queue never offers a job that the front end did not put there.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pop_valid && !(push_valid && push_ready) |=> !pop_valid)
    else $error("queue produced a job from nothing");

endmodule

### test/tb_note_lock_qualifier.sv
// Self-checking testbench for the note lock qualifier: directed frames, then random phases.
`timescale 1ns / 100ps

module tb_note_lock_qualifier;
    import nlq_pkg::*;

    // One pitch frame as the front end sees it, and one qualified result.
    typedef struct packed {
        logic                    present;
        logic [NOTE_W-1:0]       note;
        logic [NOTE_W-1:0]       octave;
        logic signed [OFF_W-1:0] offset;
        logic [HZ_W-1:0]         hz;
    } frame_t;

    typedef struct packed {
        logic                    seen;
        logic [NOTE_W-1:0]       note;
        logic [NOTE_W-1:0]       octave;
        logic                    confirmed;
        logic signed [OFF_W-1:0] mean;
        logic [HZ_W-1:0]         freq;
        logic                    locked;
        logic                    changed;
    } verdict_t;

    // A directed row either carries its expected verdict, typed in by hand, or leaves
    // the verdict to the tracker below.
    typedef struct packed {
        frame_t   frame;
        logic     typed;
        verdict_t want;
    } dir_row_t;

    // A random phase: threshold pair, number of frames and the shape of the traffic.
    typedef struct {
        logic [CFG_W-1:0] confirm;
        logic [CFG_W-1:0] miss;
        int               frames;
        int               run_max;
        int               gap_max;
    } phase_t;

    localparam int FRAME_BITS = $bits(frame_t);

    // A threshold of this value in the phase list means "draw a small one at random".
    localparam logic [CFG_W-1:0] PICK = 8'hFF;

    // The phase with no idling on either side, and the phase in which the receiver
    // holds off for a long stretch while frames keep coming.
    localparam int CALM_PHASE = 2;
    localparam int HOLD_PHASE = 3;
    localparam int HOLD_OFF   = 300;

    // The slowest correct gap between two transfers is the receiver hold-off plus one
    // confirming frame through the divider, plus a random stall or two. Several times
    // that is allowed before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;

    localparam int N_PHASES = 7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    nlq_frame_if  frame_ch ();
    nlq_result_if result_ch ();

    note_lock_qualifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_ch),
        .result    (result_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Lock tracker: the testbench's own copy of the qualifier state, advanced
    // once for every frame transfer. Values start at their reset state.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]  confirm_thr = CONFIRM_RESET;
    logic [CFG_W-1:0]  miss_thr    = MISS_RESET;
    logic [NOTE_W-1:0] last_note   = '0;
    logic [NOTE_W-1:0] last_octave = '0;
    logic              last_valid  = 1'b0;
    logic [CNT_W-1:0]  hit_cnt     = '0;
    logic [CNT_W-1:0]  miss_cnt    = '0;
    logic              lock_held   = 1'b0;
    int                win_vals [WINDOW];
    int                win_head    = 0;
    int                win_fill    = 0;
    int                win_sum     = 0;

    verdict_t awaited_verdicts [$];
    int       mismatches    = 0;
    int       verdicts_seen = 0;
    logic     calm          = 1'b0;
    logic     hold_req      = 1'b0;

    function automatic void clear_window();
        win_head = 0;
        win_fill = 0;
        win_sum  = 0;
    endfunction

    // A full window loses its oldest offset before the new one goes in.
    function automatic void push_offset(int v);
        if (win_fill >= WINDOW)
        begin
            win_sum  -= win_vals[win_head];
            win_head = (win_head + 1) % WINDOW;
            win_fill = WINDOW - 1;
        end
        win_vals[(win_head + win_fill) % WINDOW] = v;
        win_fill++;
        win_sum += v;
    endfunction

    // The old miss count is compared with the threshold before the saturating
    // increment. Going over clears the hits, and drops a held lock with its window.
    function automatic logic tally_miss();
        logic over;
        logic dropped;
        over    = (miss_cnt >= miss_thr);
        dropped = 1'b0;
        if (miss_cnt != CNT_MAX)
            miss_cnt++;
        if (over)
        begin
            hit_cnt = '0;
            if (lock_held)
            begin
                lock_held = 1'b0;
                clear_window();
                dropped = 1'b1;
            end
        end
        return dropped;
    endfunction

    function automatic verdict_t qualify_frame(frame_t f);
        verdict_t v;
        logic     over;
        v      = '0;
        v.seen = f.present;
        if (f.present)
        begin
            v.note   = f.note;
            v.octave = f.octave;
            // A new note or octave, or the first pitched frame since reset, restarts
            // the hit count and the window, and is itself counted as a miss.
            if (!last_valid || f.note != last_note || f.octave != last_octave)
            begin
                last_note   = f.note;
                last_octave = f.octave;
                last_valid  = 1'b1;
                hit_cnt     = '0;
                if (tally_miss())
                    v.changed = 1'b1;
                clear_window();
                push_offset(int'(f.offset));
            end
            else
            begin
                over = (hit_cnt >= confirm_thr);
                if (hit_cnt != CNT_MAX)
                    hit_cnt++;
                push_offset(int'(f.offset));
                if (over)
                begin
                    // The mean is a signed division that truncates towards zero.
                    miss_cnt    = '0;
                    v.confirmed = 1'b1;
                    v.mean      = OFF_W'(win_sum / win_fill);
                    v.freq      = f.hz;
                    lock_held   = 1'b1;
                    v.changed   = 1'b1;
                end
            end
        end
        else if (tally_miss())
        begin
            v.changed = 1'b1;
        end
        v.locked = lock_held;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Directed frames, run with both thresholds at their reset value of 3.
    // The first rows take a note from nothing to a lock at the largest offset
    // and frequency; later rows fill and wrap the window with the most negative
    // offset, drop the lock through a run of missing pitches, use a note index
    // outside the octave, and show the mean truncating towards zero (-7 / 5).
    // ------------------------------------------------------------------------
    dir_row_t frame_table [24] = '{
        '{'{1'b0, 4'd0,  4'd0,  16'sd0,     16'd0},     1'b1,
          '{1'b0, 4'd0,  4'd0,  1'b0, 16'sd0,     16'd0,     1'b0, 1'b0}},
        '{'{1'b1, 4'd11, 4'd15, 16'sd32767, 16'hFFFF},  1'b1,
          '{1'b1, 4'd11, 4'd15, 1'b0, 16'sd0,     16'd0,     1'b0, 1'b0}},
        '{'{1'b1, 4'd11, 4'd15, 16'sd32767, 16'hFFFF},  1'b1,
          '{1'b1, 4'd11, 4'd15, 1'b0, 16'sd0,     16'd0,     1'b0, 1'b0}},
        '{'{1'b1, 4'd11, 4'd15, 16'sd32767, 16'hFFFF},  1'b1,
          '{1'b1, 4'd11, 4'd15, 1'b0, 16'sd0,     16'd0,     1'b0, 1'b0}},
        '{'{1'b1, 4'd11, 4'd15, 16'sd32767, 16'hFFFF},  1'b1,
          '{1'b1, 4'd11, 4'd15, 1'b0, 16'sd0,     16'd0,     1'b0, 1'b0}},
        '{'{1'b1, 4'd11, 4'd15, 16'sd32767, 16'hFFFF},  1'b1,
          '{1'b1, 4'd11, 4'd15, 1'b1, 16'sd32767, 16'hFFFF,  1'b1, 1'b1}},
        '{'{1'b1, 4'd11, 4'd15, 16'sh8000,  16'd0},     1'b0, '0},
        '{'{1'b1, 4'd11, 4'd15, 16'sh8000,  16'd1},     1'b0, '0},
        '{'{1'b1, 4'd11, 4'd15, 16'sh8000,  16'd2},     1'b0, '0},
        '{'{1'b1, 4'd11, 4'd15, 16'sh8000,  16'd3},     1'b0, '0},
        '{'{1'b1, 4'd11, 4'd15, -16'sd1,    16'd100},   1'b0, '0},
        '{'{1'b1, 4'd0,  4'd0,  16'sd0,     16'd0},     1'b0, '0},
        '{'{1'b0, 4'd0,  4'd0,  16'sd0,     16'd0},     1'b0, '0},
        '{'{1'b0, 4'd0,  4'd0,  16'sd0,     16'd0},     1'b0, '0},
        '{'{1'b0, 4'd0,  4'd0,  16'sd0,     16'd0},     1'b1,
          '{1'b0, 4'd0,  4'd0,  1'b0, 16'sd0,     16'd0,     1'b0, 1'b1}},
        '{'{1'b0, 4'd0,  4'd0,  16'sd0,     16'd0},     1'b1,
          '{1'b0, 4'd0,  4'd0,  1'b0, 16'sd0,     16'd0,     1'b0, 1'b0}},
        '{'{1'b1, 4'd15, 4'd0,  -16'sd1,    16'd7},     1'b0, '0},
        '{'{1'b1, 4'd15, 4'd0,  -16'sd2,    16'd7},     1'b0, '0},
        '{'{1'b1, 4'd15, 4'd0,  -16'sd1,    16'd7},     1'b0, '0},
        '{'{1'b1, 4'd15, 4'd0,  -16'sd2,    16'd7},     1'b0, '0},
        '{'{1'b1, 4'd15, 4'd0,  -16'sd1,    16'd9},     1'b0, '0},
        '{'{1'b1, 4'd12, 4'd8,  16'sd16384, 16'd1234},  1'b0, '0},
        '{'{1'b1, 4'd3,  4'd4,  -16'sd16384, 16'hAAAA}, 1'b0, '0},
        '{'{1'b0, 4'd15, 4'd15, -16'sd1,    16'hFFFF},  1'b0, '0}
    };

    // Threshold settings for the random part: the reset-free extremes, a short pair,
    // and two pairs drawn at random. The second phase uses long runs and long gaps so
    // that both counters reach their saturation value.
    phase_t phases [N_PHASES] = '{
        '{8'd0,   8'd0,   200, 12,  6},
        '{8'd254, 8'd254, 600, 300, 270},
        '{8'd1,   8'd2,   250, 10,  5},
        '{8'd0,   8'd254, 200, 12,  6},
        '{8'd254, 8'd0,   200, 12,  6},
        '{PICK,   PICK,   250, 12,  8},
        '{PICK,   PICK,   250, 12,  8}
    };

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Frame side. Every task here is entered at a falling edge and returns at a
    // falling edge, so that valid is never assigned twice in one time step.
    // ------------------------------------------------------------------------
    task automatic offer_frame(frame_t f, logic typed = 1'b0, verdict_t want = '0);
        verdict_t v;
        while (!calm && $urandom_range(0, 99) < 35)
        begin
            frame_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frame_ch.valid           <= 1'b1;
        frame_ch.pitch_present   <= f.present;
        frame_ch.note_index      <= f.note;
        frame_ch.octave_index    <= f.octave;
        frame_ch.semitone_offset <= f.offset;
        frame_ch.pitch_hz        <= f.hz;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        // The transfer has happened: advance the tracker whether or not the row
        // carries its own expectation, so that its state stays in step.
        v = qualify_frame(f);
        awaited_verdicts.push_back(typed ? want : v);
        @(negedge clk);
    endtask

    // Stop offering and wait until every outstanding result has been taken.
    task automatic settle();
        frame_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_verdicts.size() != 0);
    endtask

    // Both registers are written on consecutive edges with the block idle.
    task automatic program_thresholds(logic [CFG_W-1:0] conf_val, logic [CFG_W-1:0] miss_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CONFIRM;
        cfg_data  <= conf_val;
        @(negedge clk);
        cfg_index <= CFG_MISS;
        cfg_data  <= miss_val;
        @(negedge clk);
        cfg_we      <= 1'b0;
        confirm_thr = conf_val;
        miss_thr    = miss_val;
    endtask

    // Random traffic is mostly runs of one note with jittered or random offsets, so
    // that hit counts climb and locks form; gaps of missing pitch drop them again, and
    // the odd frame is pure noise. Runs are now and then broken by a stray unpitched frame or, if short, note.
    task automatic drive_phase(int frames, int run_max, int gap_max);
        int               sent;
        int               span;
        int               kind;
        frame_t           f;
        frame_t           stray;
        logic [OFF_W-1:0] centre;
        sent = 0;
        while (sent < frames)
        begin
            kind      = $urandom_range(0, 99);
            f.present = 1'b1;
            f.note    = ($urandom_range(0, 9) == 0) ? NOTE_W'($urandom_range(12, 15))
                                                    : NOTE_W'($urandom_range(0, 11));
            f.octave  = NOTE_W'($urandom_range(0, 15));
            if (kind < 70)
            begin
                span   = (run_max > 100) ? $urandom_range(run_max - 40, run_max)
                                         : $urandom_range(1, run_max);
                centre = OFF_W'($urandom);
                for (int i = 0; i < span && sent < frames; i++)
                begin
                    f.hz     = HZ_W'($urandom);
                    f.offset = ($urandom_range(0, 1) == 1)
                               ? OFF_W'($urandom)
                               : centre + OFF_W'($urandom_range(0, 511)) - 16'd256;
                    if ($urandom_range(0, 99) < 8)
                    begin
                        stray = f;
                        if (run_max > 100 || $urandom_range(0, 1) == 1)
                            stray.present = 1'b0;
                        else
                            stray.note = stray.note ^ NOTE_W'($urandom_range(1, 15));
                        offer_frame(stray);
                        sent++;
                    end
                    offer_frame(f);
                    sent++;
                end
            end
            else if (kind < 85)
            begin
                span = (gap_max > 100) ? $urandom_range(gap_max - 20, gap_max)
                                       : $urandom_range(1, gap_max);
                for (int i = 0; i < span && sent < frames; i++)
                begin
                    f.present = 1'b0;
                    f.offset  = OFF_W'($urandom);
                    f.hz      = HZ_W'($urandom);
                    offer_frame(f);
                    sent++;
                end
            end
            else
            begin
                f = FRAME_BITS'({$urandom, $urandom});
                offer_frame(f);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready is chosen at each falling edge. When asked, the
    // receiver refuses results for a long stretch so that the internal queue
    // fills and the frame side sees ready fall.
    // ------------------------------------------------------------------------
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF)
                    @(negedge clk);
            end
            result_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
        end
    end

    // Each result transfer is compared field by field with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.seen      = result_ch.pitch_seen;
            got.note      = result_ch.note_out;
            got.octave    = result_ch.octave_out;
            got.confirmed = result_ch.confirmed;
            got.mean      = result_ch.mean_offset;
            got.freq      = result_ch.freq_out;
            got.locked    = result_ch.locked;
            got.changed   = result_ch.changed;
            verdicts_seen++;
            if (awaited_verdicts.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", verdicts_seen, 0);
            end
            else
            begin
                want = awaited_verdicts.pop_front();
                if (got.seen != want.seen)
                    report_mismatch("pitch_seen", got.seen, want.seen);
                if (got.note != want.note)
                    report_mismatch("note_out", got.note, want.note);
                if (got.octave != want.octave)
                    report_mismatch("octave_out", got.octave, want.octave);
                if (got.confirmed != want.confirmed)
                    report_mismatch("confirmed", got.confirmed, want.confirmed);
                if (got.mean != want.mean)
                    report_mismatch("mean_offset", longint'(got.mean), longint'(want.mean));
                if (got.freq != want.freq)
                    report_mismatch("freq_out", got.freq, want.freq);
                if (got.locked != want.locked)
                    report_mismatch("locked", got.locked, want.locked);
                if (got.changed != want.changed)
                    report_mismatch("changed", got.changed, want.changed);
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, the directed table, then the random phases, each begun
    // with the block drained and fresh thresholds written.
    // ------------------------------------------------------------------------
    initial
    begin
        phase_t           ph;
        logic [CFG_W-1:0] conf_val;
        logic [CFG_W-1:0] miss_val;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = CFG_CONFIRM;
        cfg_data                 = '0;
        frame_ch.valid           = 1'b0;
        frame_ch.pitch_present   = 1'b0;
        frame_ch.note_index      = '0;
        frame_ch.octave_index    = '0;
        frame_ch.semitone_offset = '0;
        frame_ch.pitch_hz        = '0;
        foreach (win_vals[i])
            win_vals[i] = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (frame_table[i])
            offer_frame(frame_table[i].frame, frame_table[i].typed, frame_table[i].want);
        settle();

        for (int p = 0; p < N_PHASES; p++)
        begin
            ph       = phases[p];
            conf_val = (ph.confirm == PICK) ? CFG_W'($urandom_range(0, 6)) : ph.confirm;
            miss_val = (ph.miss == PICK) ? CFG_W'($urandom_range(0, 6)) : ph.miss;
            program_thresholds(conf_val, miss_val);
            calm = (p == CALM_PHASE);
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            drive_phase(ph.frames, ph.run_max, ph.gap_max);
            settle();
        end

        // A short pause lets any surplus result show itself before the verdict.
        repeat (40)
            @(negedge clk);
        if (awaited_verdicts.size() != 0)
            report_mismatch("results never delivered", awaited_verdicts.size(), 0);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/nlq_pkg.sv
rtl/nlq_if.sv
rtl/nlq_front.sv
rtl/nlq_queue.sv
rtl/nlq_back.sv
rtl/note_lock_qualifier.sv
test/tb_note_lock_qualifier.sv
